// ===== hdl/nird_pkg.sv =====
// ----------------------------------------------------------------------------
// nird_pkg
// Types and constants shared by the NEC infrared pulse-distance decoder.
// ----------------------------------------------------------------------------
package nird_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BIT_IDX_W  = $clog2(FRAME_BITS);

  localparam logic [31:0] GLITCH_MAX_US = 32'd844;
  localparam logic [31:0] RESET_OVER_US = 32'd2500;
  localparam logic [31:0] ONE_OVER_US   = 32'd1688;

  localparam logic [8:0]  KEY_SUM       = 9'd255;

  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic CFG_REMOTE_FILTER = 1'b0;
  localparam logic CFG_VERIFY_KEY    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] edge_time_us;
  } nird_in_t;

  typedef struct packed {
    logic        code_ready;
    logic        frame_done;
    logic [15:0] held_command;
    logic [7:0]  held_button;
    logic [15:0] held_remote;
  } nird_out_t;

  typedef struct packed {
    logic [15:0] remote_filter;
    logic        verify_key;
  } nird_cfg_t;

endpackage

// ===== hdl/nird_decode.sv =====
// ----------------------------------------------------------------------------
// nird_decode
// Decoder state and single-pass next-state logic: interval measurement,
// bit classification, frame check, latch of command, key and remote id, and clear of the held command.
// ----------------------------------------------------------------------------
module nird_decode
  import nird_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  nird_in_t  item,
  input  nird_cfg_t cfg,
  output nird_out_t result
);

  logic [31:0]          last_edge_time_r, last_edge_time_nxt;
  logic [31:0]          shift_acc_r, shift_acc_nxt;
  logic [BIT_IDX_W-1:0] bit_index_r, bit_index_nxt;
  logic [15:0]          command_r, command_nxt;
  logic [7:0]           button_r, button_nxt;
  logic [15:0]          remote_r, remote_nxt;

  logic [31:0] interval;
  logic [31:0] acc_set;
  logic [8:0]  key_sum;
  logic        accept;
  logic        done;

  assign interval = item.edge_time_us - last_edge_time_r;
  assign acc_set  = (interval > ONE_OVER_US)
                  ? (shift_acc_r | (32'd1 << bit_index_r)) : shift_acc_r;
  assign key_sum  = {1'b0, acc_set[31:24]} + {1'b0, acc_set[23:16]};
  assign accept   = ((cfg.remote_filter == 16'd0) || (acc_set[15:0] == cfg.remote_filter))
                 && (!cfg.verify_key || (key_sum == KEY_SUM));

  always_comb begin
    last_edge_time_nxt = last_edge_time_r;
    shift_acc_nxt      = shift_acc_r;
    bit_index_nxt      = bit_index_r;
    command_nxt        = command_r;
    button_nxt         = button_r;
    remote_nxt         = remote_r;
    done               = 1'b0;
    if (item.action == ACT_CLEAR) begin
      command_nxt = 16'd0;
    end else if ((command_r == 16'd0) && (interval > GLITCH_MAX_US)) begin
      last_edge_time_nxt = item.edge_time_us;
      if (interval > RESET_OVER_US) begin
        shift_acc_nxt = 32'd0;
        bit_index_nxt = '0;
      end else if (bit_index_r != BIT_IDX_W'(FRAME_BITS - 1)) begin
        shift_acc_nxt = acc_set;
        bit_index_nxt = bit_index_r + BIT_IDX_W'(1);
      end else begin
        shift_acc_nxt = 32'd0;
        bit_index_nxt = '0;
        if (accept) begin
          command_nxt = acc_set[31:16];
          button_nxt  = acc_set[23:16];
          remote_nxt  = acc_set[15:0];
          done        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_time_r <= 32'd0;
      shift_acc_r      <= 32'd0;
      bit_index_r      <= '0;
      command_r        <= 16'd0;
      button_r         <= 8'd0;
      remote_r         <= 16'd0;
    end else if (step) begin
      last_edge_time_r <= last_edge_time_nxt;
      shift_acc_r      <= shift_acc_nxt;
      bit_index_r      <= bit_index_nxt;
      command_r        <= command_nxt;
      button_r         <= button_nxt;
      remote_r         <= remote_nxt;
    end
  end

  assign result.code_ready   = (command_nxt != 16'd0);
  assign result.frame_done   = done;
  assign result.held_command = command_nxt;
  assign result.held_button  = button_nxt;
  assign result.held_remote  = remote_nxt;

endmodule

// ===== hdl/nec_ir_pulse_distance_decoder_top.sv =====
// ----------------------------------------------------------------------------
// nec_ir_pulse_distance_decoder_top
// NEC infrared remote decoder fed with timestamped falling-edge items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one event per item:
//   a falling edge with its microsecond timestamp, or a clear of the held
//   code. Every input item gives exactly one result item on the output
//   channel (out_valid / out_stall / out_data) with the held code and a
//   frame-done flag.
//   The input register feeds the decode logic, which updates the decoder
//   state and the result register when the item advances.
//   Throughput: 1 item per cycle while out_stall is low.
//   Stall: the result register holds while it is valid and out_stall is high;
//   one further item waits in the input register, then in_stall rises.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready: index 0 is the remote filter, index 1 the key check enable (bit 0).
//   Write it only while no item is in flight.
//   Reset (rst_n low, synchronous) clears all decoder state, the
//   configuration and the valid flags of both pipeline registers.
// ----------------------------------------------------------------------------
module nec_ir_pulse_distance_decoder_top
  import nird_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  nird_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output nird_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic      s1_valid_r;
  nird_in_t  s1_item_r;
  logic      out_valid_r;
  nird_out_t out_r;
  nird_cfg_t cfg_r;
  nird_out_t result;
  logic      advance;
  logic      in_take;

  assign advance   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REMOTE_FILTER: cfg_r.remote_filter <= cfg_data;
        CFG_VERIFY_KEY:    cfg_r.verify_key    <= cfg_data[0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  nird_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/nird_checker.sv =====
// ----------------------------------------------------------------------------
// nird_checker
// Port-level checks for the NEC infrared decoder, bound to the top level.
// ----------------------------------------------------------------------------
module nird_checker
  import nird_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input nird_out_t out_data
);

  a_reset_idle : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_ready_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.code_ready == (out_data.held_command != 16'd0)))
    else $error("code_ready disagrees with held command");

  a_button : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.held_button == out_data.held_command[7:0])
    else $error("latched button is not the command low byte");

endmodule

bind nec_ir_pulse_distance_decoder_top nird_checker u_nird_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/nird_decode_checker.sv =====
// ----------------------------------------------------------------------------
// nird_decode_checker
// Watches the event, result and configuration channels of the NEC infrared
// decoder. It keeps its own copy of the decoder state and settings, works out
// the result of every accepted event item, and compares each accepted result
// item with the oldest one still waiting, field by field.
// ----------------------------------------------------------------------------
module nird_decode_checker
  import nird_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  nird_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  nird_out_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [15:0]          remote_filter_q;
  logic                 verify_key_q;
  logic [31:0]          last_edge_us;
  logic [31:0]          frame_acc;
  logic [BIT_IDX_W-1:0] bit_pos;
  logic [15:0]          command_q;
  logic [7:0]           button_q;
  logic [15:0]          remote_q;

  nird_out_t   expected_results[$];
  nird_out_t   oldest;
  nird_out_t   predicted;
  int unsigned mismatches = 0;

  function automatic logic frame_passes(logic [31:0] frame);
    logic [8:0] key_sum;
    key_sum = {1'b0, frame[31:24]} + {1'b0, frame[23:16]};
    if (remote_filter_q != 16'd0 && frame[15:0] != remote_filter_q) return 1'b0;
    if (verify_key_q && key_sum != KEY_SUM) return 1'b0;
    return 1'b1;
  endfunction

  function automatic nird_out_t decode_event(nird_in_t ev);
    nird_out_t   res;
    logic [31:0] interval;
    logic        done;
    done = 1'b0;
    if (ev.action == ACT_CLEAR) begin
      command_q = 16'd0;
    end else if (command_q == 16'd0) begin
      interval = ev.edge_time_us - last_edge_us;
      if (interval > GLITCH_MAX_US) begin
        if (interval > RESET_OVER_US) begin
          frame_acc = 32'd0;
          bit_pos   = '0;
        end else begin
          if (interval > ONE_OVER_US) frame_acc[bit_pos] = 1'b1;
          if (bit_pos < FRAME_BITS - 1) begin
            bit_pos = bit_pos + 1'b1;
          end else begin
            if (frame_passes(frame_acc)) begin
              command_q = frame_acc[31:16];
              remote_q  = frame_acc[15:0];
              button_q  = frame_acc[23:16];
              done      = 1'b1;
            end
            frame_acc = 32'd0;
            bit_pos   = '0;
          end
        end
        last_edge_us = ev.edge_time_us;
      end
    end
    res.code_ready   = (command_q != 16'd0);
    res.frame_done   = done;
    res.held_command = command_q;
    res.held_button  = button_q;
    res.held_remote  = remote_q;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      remote_filter_q = 16'd0;
      verify_key_q    = 1'b0;
      last_edge_us    = 32'd0;
      frame_acc       = 32'd0;
      bit_pos         = '0;
      command_q       = 16'd0;
      button_q        = 8'd0;
      remote_q        = 16'd0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REMOTE_FILTER: remote_filter_q = cfg_data;
          CFG_VERIFY_KEY:    verify_key_q    = cfg_data[0];
          default:           ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: ready=%0d done=%0d cmd=%h btn=%h rem=%h",
                     out_data.code_ready, out_data.frame_done, out_data.held_command,
                     out_data.held_button, out_data.held_remote);
        end else begin
          oldest = expected_results.pop_front();
          if (oldest.code_ready   !== out_data.code_ready   ||
              oldest.frame_done   !== out_data.frame_done   ||
              oldest.held_command !== out_data.held_command ||
              oldest.held_button  !== out_data.held_button  ||
              oldest.held_remote  !== out_data.held_remote) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch, expected: ready=%0d done=%0d cmd=%h btn=%h rem=%h",
                       oldest.code_ready, oldest.frame_done, oldest.held_command,
                       oldest.held_button, oldest.held_remote);
              $display("result mismatch, actual:   ready=%0d done=%0d cmd=%h btn=%h rem=%h",
                       out_data.code_ready, out_data.frame_done, out_data.held_command,
                       out_data.held_button, out_data.held_remote);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted = decode_event(in_data);
        expected_results.push_back(predicted);
      end
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
  end

endmodule

// ===== tb/tb_nec_ir_pulse_distance_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_nec_ir_pulse_distance_decoder_top
// Drives the NEC infrared decoder with timestamped edge and clear items:
// boundary intervals and timestamp wrap first, then phases of random frames
// with random content, glitches, truncated and overlong frames and noise,
// under several filter and key-check settings, idling and stall patterns. A
// separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_nec_ir_pulse_distance_decoder_top;
  import nird_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 300000;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned PHASE_ITEMS      = 315;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  nird_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  nird_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned sent_items    = 0;
  int unsigned cycle_count   = 0;
  logic [31:0] last_edge_us  = 32'd0;
  logic [15:0] remote_filter_sel = 16'd0;

  nec_ir_pulse_distance_decoder_top dut (.*);
  nird_decode_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_nec_ir_pulse_distance_decoder_top NOT OK");
    $finish;
  end

  task automatic send_item(input logic action, input logic [31:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {action, stamp};
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic send_edge(input logic [31:0] interval);
    logic [31:0] stamp;
    stamp = last_edge_us + interval;
    send_item(ACT_EDGE, stamp);
    if (interval > GLITCH_MAX_US) last_edge_us = stamp;
  endtask

  task automatic send_clear();
    send_item(ACT_CLEAR, $urandom());
  endtask

  function automatic logic [31:0] bit_interval(logic one);
    case ($urandom_range(7))
      0:       return one ? ONE_OVER_US + 1 : GLITCH_MAX_US + 1;
      1:       return one ? RESET_OVER_US : ONE_OVER_US;
      default: return one ? $urandom_range(RESET_OVER_US, ONE_OVER_US + 1)
                          : $urandom_range(ONE_OVER_US, GLITCH_MAX_US + 1);
    endcase
  endfunction

  task automatic send_leader();
    logic [31:0] interval;
    case ($urandom_range(3))
      0:       interval = RESET_OVER_US + 1;
      1:       interval = $urandom();
      default: interval = $urandom_range(13500, 9000);
    endcase
    if (interval <= RESET_OVER_US) interval = 32'hFFFF_FFFF;
    send_edge(interval);
  endtask

  task automatic send_frame(input int unsigned bit_count);
    logic [15:0] remote;
    logic [7:0]  key;
    logic [7:0]  inv;
    logic [31:0] word;
    remote = (remote_filter_sel != 16'd0 && $urandom_range(3) != 0) ? remote_filter_sel
                                                                   : 16'($urandom());
    key = 8'($urandom());
    inv = ($urandom_range(3) != 0) ? ~key : 8'($urandom());
    if ($urandom_range(7) == 0) begin
      key = 8'd0;
      inv = 8'd0;
    end
    word = {inv, key, remote};
    send_leader();
    for (int i = 0; i < bit_count; i++) begin
      if ($urandom_range(9) == 0) send_edge($urandom_range(GLITCH_MAX_US));
      send_edge(bit_interval(word[i % FRAME_BITS]));
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(input logic index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic run_phase(input logic [15:0] filter, input logic verify,
                           input int unsigned idle, input int unsigned stall,
                           input logic long_hold);
    int unsigned stop_at;
    int unsigned pick;
    wait_for_results();
    write_cfg(CFG_REMOTE_FILTER, filter);
    write_cfg(CFG_VERIFY_KEY, {15'd0, verify});
    cfg_valid <= 1'b0;
    remote_filter_sel = filter;
    idle_pct  = idle;
    stall_pct = stall;
    if (long_hold) hold_requests++;
    stop_at = sent_items + PHASE_ITEMS;
    while (sent_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(FRAME_BITS);
        repeat ($urandom_range(2)) send_edge($urandom_range(3000));
        if ($urandom_range(7) != 0) send_clear();
      end else if (pick < 82) begin
        send_frame($urandom_range(FRAME_BITS - 1, 1));
      end else if (pick < 88) begin
        send_frame(FRAME_BITS + 1);
      end else begin
        repeat ($urandom_range(4, 1)) send_item(1'($urandom_range(1)), $urandom());
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_REMOTE_FILTER;
    cfg_data  <= 16'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boundary intervals, then timestamp wrap
    send_edge(32'd0);
    send_edge(GLITCH_MAX_US);
    send_edge(GLITCH_MAX_US + 1);
    send_edge(ONE_OVER_US);
    send_edge(ONE_OVER_US + 1);
    send_edge(RESET_OVER_US);
    send_edge(RESET_OVER_US + 1);
    send_clear();
    send_item(ACT_EDGE, 32'hFFFF_FFFF);
    last_edge_us = 32'hFFFF_FFFF;
    send_edge(32'd1000);
    send_edge(32'hFFFF_FFFF);
    send_item(ACT_CLEAR, 32'd0);

    run_phase(16'd0, 1'b0, 0, 0, 1'b0);
    run_phase(16'hFFFF, 1'b1, 67, 0, 1'b0);
    run_phase(16'($urandom_range(16'hFFFE, 1)), 1'b0, 0, 67, 1'b1);
    run_phase(16'd0, 1'b1, 22, 22, 1'b0);
    run_phase(16'($urandom_range(16'hFFFE, 1)), 1'b1, 0, 0, 1'b0);
    run_phase(16'hFFFF, 1'b0, 67, 67, 1'b0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_nec_ir_pulse_distance_decoder_top OK");
    end else begin
      $display("tb_nec_ir_pulse_distance_decoder_top NOT OK");
    end
    $finish;
  end

endmodule
